// ===== design/text_tokenizer_top_macros.svh =====
// ----------------------------------------------------------------------------
// text_tokenizer_top_macros.svh
// Assertion macros used by the verification file of the tokenizer.
// ----------------------------------------------------------------------------
`ifndef TEXT_TOKENIZER_TOP_MACROS_SVH
`define TEXT_TOKENIZER_TOP_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define TTOK_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define TTOK_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== design/ttok_pkg.sv =====
// ----------------------------------------------------------------------------
// ttok_pkg
// Token class codes, byte class codes, the result word type and the byte
// classifier function of the text tokenizer.
// ----------------------------------------------------------------------------
package ttok_pkg;

   localparam logic [2:0] TK_WS      = 3'd0;
   localparam logic [2:0] TK_NUM     = 3'd1;
   localparam logic [2:0] TK_STR     = 3'd2;
   localparam logic [2:0] TK_NL      = 3'd3;
   localparam logic [2:0] TK_UNK     = 3'd4;
   localparam logic [2:0] TK_END     = 3'd5;
   localparam logic [2:0] KIND_NONE  = 3'd7;

   localparam logic [2:0] CL_WS      = 3'd0;
   localparam logic [2:0] CL_DIGIT   = 3'd1;
   localparam logic [2:0] CL_NAME    = 3'd2;
   localparam logic [2:0] CL_NL      = 3'd3;
   localparam logic [2:0] CL_UNK     = 3'd4;

   localparam int START_W  = 32;
   localparam int LENGTH_W = 16;

   typedef struct packed {
      logic [2:0]          token_class;
      logic [START_W-1:0]  token_start;
      logic [LENGTH_W-1:0] token_length;
      logic                last_of_run;
   } result_type;

   function automatic logic [2:0] byte_class_f(input logic [7:0] b);
      logic [2:0] c;
      if (b == 8'd32 || b == 8'd9) begin
         c = CL_WS;
      end else if (b >= 8'd48 && b <= 8'd57) begin
         c = CL_DIGIT;
      end else if ((b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122)) begin
         c = CL_NAME;
      end else if (b == 8'd45 || b == 8'd63 || b == 8'd95 || b == 8'd124) begin
         c = CL_NAME;
      end else if (b == 8'd10 || b == 8'd13) begin
         c = CL_NL;
      end else begin
         c = CL_UNK;
      end
      return c;
   endfunction

endpackage

// ===== design/text_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// text_tokenizer_top
// Classifies a text one byte at a time and merges runs of bytes into tokens
// that carry class, start offset and length.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              word
//  req      in         req_valid / req_stall  text byte or end of text
//  rsp      out        rsp_valid / rsp_stall  token class, start, length, last
//
//  One req word is taken per cycle while req_stall is low; the token update
//  is combinational logic behind the pending-token registers.
//  A word yields zero, one or two rsp words into a four-entry result queue;
//  req_stall is high while the queue holds more than two words.
//  A rsp word is written into the result queue when its req word is taken.
//  Reset clears the pending token, the offset and the queue.
// ----------------------------------------------------------------------------
module text_tokenizer_top
   import ttok_pkg::*;
#(
   parameter int OFFSET_BITS = 32,
   parameter int LENGTH_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_text_byte,
   input  logic                req_end_of_text,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_token_class,
   output logic [START_W-1:0]  rsp_token_start,
   output logic [LENGTH_W-1:0] rsp_token_length,
   output logic                rsp_last_of_run
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [2:0]             kind_ff, kind_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;

   result_type             queue_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]       fill_ff;

   logic [START_W-1:0]     pend_start_w;
   logic [START_W-1:0]     offset_w;
   logic [LENGTH_W-1:0]    pend_len_w;
   logic [2:0]             cls;
   logic                   extend;
   logic                   accept, pop;
   logic                   push0, push1;
   result_type             res0, res1;

   generate
      if (OFFSET_BITS >= START_W) begin : g_start_trunc
         assign pend_start_w = start_ff[START_W-1:0];
         assign offset_w     = offset_ff[START_W-1:0];
      end else begin : g_start_ext
         assign pend_start_w = {{(START_W-OFFSET_BITS){1'b0}}, start_ff};
         assign offset_w     = {{(START_W-OFFSET_BITS){1'b0}}, offset_ff};
      end
      if (LENGTH_BITS > LENGTH_W) begin : g_len_sat
         assign pend_len_w = (|count_ff[LENGTH_BITS-1:LENGTH_W]) ? {LENGTH_W{1'b1}}
                                                                  : count_ff[LENGTH_W-1:0];
      end else if (LENGTH_BITS == LENGTH_W) begin : g_len_same
         assign pend_len_w = count_ff;
      end else begin : g_len_ext
         assign pend_len_w = {{(LENGTH_W-LENGTH_BITS){1'b0}}, count_ff};
      end
   endgenerate

   assign req_stall = reset || (fill_ff > CNT_W'(DEPTH - 2));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (fill_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;

   assign cls = byte_class_f(req_text_byte);

   always_comb begin
      extend = 1'b0;
      unique case (kind_ff)
         TK_WS:   extend = (cls == CL_WS);
         TK_NUM:  extend = (cls == CL_DIGIT) || (cls == CL_NAME);
         TK_STR:  extend = (cls == CL_NAME) || (cls == CL_DIGIT);
         TK_NL:   extend = (cls == CL_NL);
         default: extend = 1'b0;
      endcase
   end

   always_comb begin
      kind_in   = kind_ff;
      start_in  = start_ff;
      count_in  = count_ff;
      offset_in = offset_ff;
      push0     = 1'b0;
      push1     = 1'b0;
      res0.token_class  = kind_ff;
      res0.token_start  = pend_start_w;
      res0.token_length = pend_len_w;
      res0.last_of_run  = 1'b1;
      res1.token_class  = TK_END;
      res1.token_start  = offset_w;
      res1.token_length = '0;
      res1.last_of_run  = 1'b1;
      if (accept) begin
         if (req_end_of_text) begin
            kind_in   = KIND_NONE;
            start_in  = '0;
            count_in  = '0;
            offset_in = '0;
            if (kind_ff != KIND_NONE) begin
               res0.last_of_run = 1'b0;
               push0 = 1'b1;
               push1 = 1'b1;
            end else begin
               res0  = res1;
               push0 = 1'b1;
            end
         end else begin
            offset_in = offset_ff + OFFSET_BITS'(1);
            if (extend) begin
               if (kind_ff == TK_NUM && cls == CL_NAME) begin
                  kind_in = TK_STR;
               end
               if (count_ff != {LENGTH_BITS{1'b1}}) begin
                  count_in = count_ff + LENGTH_BITS'(1);
               end
            end else begin
               push0    = (kind_ff != KIND_NONE);
               start_in = offset_ff;
               count_in = LENGTH_BITS'(1);
               unique case (cls)
                  CL_WS:    kind_in = TK_WS;
                  CL_DIGIT: kind_in = TK_NUM;
                  CL_NAME:  kind_in = TK_STR;
                  CL_NL:    kind_in = TK_NL;
                  default:  kind_in = TK_UNK;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_NONE;
         start_ff  <= '0;
         count_ff  <= '0;
         offset_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         kind_ff   <= kind_in;
         start_ff  <= start_in;
         count_ff  <= count_in;
         offset_ff <= offset_in;
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push0) + PTR_W'(push1);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         fill_ff   <= fill_ff + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push1) begin
         queue_ff[wr_ptr_ff + PTR_W'(1)] <= res1;
      end
   end

   assign rsp_token_class  = queue_ff[rd_ptr_ff].token_class;
   assign rsp_token_start  = queue_ff[rd_ptr_ff].token_start;
   assign rsp_token_length = queue_ff[rd_ptr_ff].token_length;
   assign rsp_last_of_run  = queue_ff[rd_ptr_ff].last_of_run;

endmodule

// ===== design/ttok_checker.sv =====
// ----------------------------------------------------------------------------
// ttok_checker
// Port-level checks of the text tokenizer, bound to its top level.
// ----------------------------------------------------------------------------
`include "text_tokenizer_top_macros.svh"

module ttok_checker
   import ttok_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [2:0]          rsp_token_class,
   input logic [START_W-1:0]  rsp_token_start,
   input logic [LENGTH_W-1:0] rsp_token_length,
   input logic                rsp_last_of_run
);

   `TTOK_ASSERT_ALWAYS(a_empty_after_reset, $past(reset) && !reset |-> !rsp_valid && !req_stall, "Not empty after reset.")
   `TTOK_ASSERT(a_rsp_held, rsp_valid && rsp_stall |=> rsp_valid, "Stalled result word was dropped.")
   `TTOK_ASSERT(a_end_word, rsp_valid && rsp_token_class == TK_END |-> rsp_token_length == '0 && rsp_last_of_run, "Bad end word.")
   `TTOK_ASSERT(a_token_word, rsp_valid && rsp_token_class != TK_END |-> rsp_token_length != '0 && rsp_token_class <= TK_UNK, "Bad token word.")

endmodule

bind text_tokenizer_top ttok_checker u_ttok_checker (.*);
